/* sv/cpuu_pkg.sv */
// Shared types and constants for the CPU utilization block.
// Used by the divider and the top level; depends on nothing.
`default_nettype none

package cpuu_pkg;

   localparam int LINE_W       = 5;     // cpu_index / line_index width
   localparam int CNT_W        = 32;    // one cumulative time counter
   localparam int NUM_COUNTERS = 9;
   localparam int PCT_W        = 15;    // percent * 256
   localparam int SLOT_W       = 4;
   localparam int REQ_DATA_W   = NUM_COUNTERS * CNT_W;               // 288
   localparam int RSP_DATA_W   = ((NUM_COUNTERS * PCT_W + 7) / 8) * 8; // 136
   localparam int RSP_USER_W   = LINE_W + 1;

   // percent with 8 fractional bits: share = delta * 100 * 256 / total
   localparam int SCALE_MUL    = 100;
   localparam int PROD_W       = CNT_W + 7;        // delta * 100 fits 39 bits
   localparam int PROD_LOW_W   = PROD_W - CNT_W;   // product bits below the first partial remainder
   localparam int FRAC_BITS    = 8;

   localparam logic [SLOT_W-1:0] IDLE_SLOT  = SLOT_W'(3);
   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(NUM_COUNTERS - 1);
   localparam logic [PCT_W-1:0]  FULL_SCALE = PCT_W'(25600);

   // sequencer states, one-hot
   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_PRIME   = 8'b0000_0010,
      ST_RD      = 8'b0000_0100,
      ST_ACC     = 8'b0000_1000,
      ST_CHK     = 8'b0001_0000,
      ST_DIVGO   = 8'b0010_0000,
      ST_DIVWAIT = 8'b0100_0000,
      ST_OUT     = 8'b1000_0000
   } seq_state_type;

   typedef logic [CNT_W-1:0] counter_type;
   typedef logic [PCT_W-1:0] pct_type;

endpackage

`default_nettype wire

/* sv/cpuu_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; holds the previous counter snapshots.
`default_nettype none

module cpuu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 288
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/cpuu_div.sv */
// Bit-serial restoring divider: floor(dividend * 25600 / divisor), saturated.
// Depends on cpuu_pkg. One quotient bit per cycle; done pulses after the last quotient bit.
`default_nettype none

module cpuu_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  cpuu_pkg::counter_type  dividend,
   input  cpuu_pkg::counter_type  divisor,   // held stable, nonzero
   output logic                   done,
   output cpuu_pkg::pct_type      quotient
);
   import cpuu_pkg::*;

   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic               sat_ff, sat_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [PCT_W-1:0]   sh_ff, sh_in;
   logic [PCT_W-1:0]   q_ff, q_in;
   logic [SLOT_W-1:0]  cnt_ff, cnt_in;
   logic               load_ff, load_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [CNT_W:0]     trial;
   logic               fits;

   // trial subtract of the divisor from the shifted partial remainder
   assign trial = {rem_ff, sh_ff[PCT_W-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      prod_in = prod_ff;
      sat_in  = sat_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      load_in = 1'b0;
      run_in  = run_ff;
      done_in = 1'b0;
      priority if (start) begin
         // delta * 100 here; the * 256 is the zero tail of the shift register
         prod_in = PROD_W'(dividend) * PROD_W'(SCALE_MUL);
         sat_in  = dividend >= divisor;
         load_in = 1'b1;
      end else if (load_ff) begin
         // top bits of the scaled dividend are already below the divisor
         rem_in = prod_ff[PROD_W-1:PROD_LOW_W];
         sh_in  = {prod_ff[PROD_LOW_W-1:0], {FRAC_BITS{1'b0}}};
         q_in   = '0;
         cnt_in = SLOT_W'(PCT_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
         q_in   = {q_ff[PCT_W-2:0], fits};
         sh_in  = {sh_ff[PCT_W-2:0], 1'b0};
         cnt_in = cnt_ff - SLOT_W'(1);
         if (cnt_ff == SLOT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end else begin
         // idle: hold
      end
   end

   // control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 1'b0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         load_ff <= load_in;
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath flops
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sat_ff  <= sat_in;
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      q_ff    <= q_in;
   end

   assign done     = done_ff;
   assign quotient = sat_ff ? FULL_SCALE : q_ff;

endmodule

`default_nettype wire

/* sv/cpu_utilization_percent.sv */
// Top level of the CPU utilization block: sequencer, snapshot RAM, shared divider.
// Depends on cpuu_pkg, cpuu_ram and cpuu_div.
`default_nettype none

// Takes one snapshot of nine cumulative 32-bit time counters for a CPU line and
// returns each category's share of the interval since that line's previous
// snapshot, for all but idle, plus the busy share, as percent * 256 (truncated, capped at 25600).
// The first snapshot of a line only primes it and gives no transfer on rsp; a
// cpu_index at or above CPU_LINES is dropped. A zero interval gives all shares
// zero with zero_interval set. The block takes one snapshot at a time: req_tready
// is high only while idle. A priming snapshot makes nine RAM writes. A full one
// runs, from the accepting edge to rsp_tvalid, the read-modify-write of the nine
// stored counters through the snapshot RAM port, the zero-total check, then nine
// passes through the single bit-serial divider; a zero-interval one stops after
// the check. No clearing pass is needed after reset.
module cpu_utilization_percent #(
   parameter int CPU_LINES = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // user, nice, system, idle, iowait, irq, softirq, steal, guest (32 bits each)
   input  logic [cpuu_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cpu_index
   input  logic [cpuu_pkg::LINE_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pct_user, pct_nice, pct_system, pct_iowait, pct_irq, pct_softirq,
   // pct_steal, pct_guest, pct_busy (15 bits each), 1 zero pad bit
   output logic [cpuu_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // line_index, zero_interval
   output logic [cpuu_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import cpuu_pkg::*;

   localparam int LW    = $clog2(CPU_LINES);
   localparam int DEPTH = CPU_LINES * NUM_COUNTERS;
   localparam int AW    = $clog2(DEPTH);

   seq_state_type          state_ff, state_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [LINE_W-1:0]      line_ff, line_in;
   logic [LW-1:0]          lidx_ff, lidx_in;
   logic [AW-1:0]          base_ff, base_in;
   counter_type            total_ff, total_in;
   logic                   zero_ff, zero_in;
   logic [CPU_LINES-1:0]   primed_ff, primed_in;
   counter_type            cur_ff [NUM_COUNTERS];
   counter_type            cur_in [NUM_COUNTERS];
   pct_type                pct_ff [NUM_COUNTERS];
   pct_type                pct_in [NUM_COUNTERS];

   logic [LW+LINE_W-1:0]   req_line_wide;
   logic [LW-1:0]          req_line;
   logic [AW+LW-1:0]       req_line_aw_wide;
   logic [AW-1:0]          req_line_aw;
   logic [AW-1:0]          req_base;
   logic                   req_in_range;
   logic [AW-1:0]          slot_addr;
   logic                   ram_wr_en;
   counter_type            ram_rd_data;
   counter_type            delta;
   counter_type            busy_part;
   counter_type            div_dividend;
   logic                   div_start;
   logic                   div_done;
   pct_type                div_quot;

   // line index and RAM row base of the incoming snapshot
   assign req_line_wide    = {{LW{1'b0}}, req_tuser};
   assign req_line         = req_line_wide[LW-1:0];
   assign req_line_aw_wide = {{AW{1'b0}}, req_line};
   assign req_line_aw      = req_line_aw_wide[AW-1:0];
   assign req_base         = (req_line_aw << 3) + req_line_aw;
   assign req_in_range     = 32'(req_tuser) < CPU_LINES;

   assign slot_addr    = base_ff + AW'(slot_ff);
   assign delta        = cur_ff[slot_ff] - ram_rd_data;
   assign busy_part    = (cur_ff[IDLE_SLOT] >= total_ff) ? '0 : total_ff - cur_ff[IDLE_SLOT];
   // busy share rides in the idle slot, which is not reported
   assign div_dividend = (slot_ff == IDLE_SLOT) ? busy_part : cur_ff[slot_ff];

   // sequencer
   always_comb begin
      state_in  = state_ff;
      slot_in   = slot_ff;
      line_in   = line_ff;
      lidx_in   = lidx_ff;
      base_in   = base_ff;
      total_in  = total_ff;
      zero_in   = zero_ff;
      primed_in = primed_ff;
      cur_in    = cur_ff;
      pct_in    = pct_ff;
      ram_wr_en = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               for (int k = 0; k < NUM_COUNTERS; k++) begin
                  cur_in[k] = req_tdata[k*CNT_W +: CNT_W];
               end
               line_in  = req_tuser;
               lidx_in  = req_line;
               base_in  = req_base;
               slot_in  = '0;
               total_in = '0;
               if (req_in_range) begin
                  state_in = primed_ff[req_line] ? ST_RD : ST_PRIME;
               end
            end
         end
         ST_PRIME: begin
            // store first snapshot, no result
            ram_wr_en = 1'b1;
            if (slot_ff == LAST_SLOT) begin
               primed_in[lidx_ff] = 1'b1;
               state_in = ST_IDLE;
            end else begin
               slot_in = slot_ff + SLOT_W'(1);
            end
         end
         ST_RD: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            // delta replaces the current value once it has been written back
            ram_wr_en       = 1'b1;
            cur_in[slot_ff] = delta;
            total_in        = total_ff + delta;
            if (slot_ff == LAST_SLOT) begin
               state_in = ST_CHK;
            end else begin
               slot_in  = slot_ff + SLOT_W'(1);
               state_in = ST_RD;
            end
         end
         ST_CHK: begin
            slot_in = '0;
            if (total_ff == '0) begin
               zero_in = 1'b1;
               for (int k = 0; k < NUM_COUNTERS; k++) begin
                  pct_in[k] = '0;
               end
               state_in = ST_OUT;
            end else begin
               zero_in  = 1'b0;
               state_in = ST_DIVGO;
            end
         end
         ST_DIVGO: begin
            div_start = 1'b1;
            state_in  = ST_DIVWAIT;
         end
         ST_DIVWAIT: begin
            if (div_done) begin
               pct_in[slot_ff] = div_quot;
               if (slot_ff == LAST_SLOT) begin
                  state_in = ST_OUT;
               end else begin
                  slot_in  = slot_ff + SLOT_W'(1);
                  state_in = ST_DIVGO;
               end
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         primed_ff <= '0;
      end else begin
         state_ff  <= state_in;
         primed_ff <= primed_in;
      end
   end

   // datapath flops
   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      line_ff  <= line_in;
      lidx_ff  <= lidx_in;
      base_ff  <= base_in;
      total_ff <= total_in;
      zero_ff  <= zero_in;
      cur_ff   <= cur_in;
      pct_ff   <= pct_in;
   end

   // previous snapshots, nine words per line
   cpuu_ram #(
      .WIDTH (CNT_W),
      .DEPTH (DEPTH)
   ) u_snap_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_addr),
      .wr_data (cur_ff[slot_ff]),
      .rd_addr (slot_addr),
      .rd_data (ram_rd_data)
   );

   cpuu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // ports
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {1'b0, pct_ff[IDLE_SLOT], pct_ff[8], pct_ff[7], pct_ff[6],
                        pct_ff[5], pct_ff[4], pct_ff[2], pct_ff[1], pct_ff[0]};
   assign rsp_tuser  = {zero_ff, line_ff};

   // checks
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result is pending");

   a_zero_shares: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[LINE_W] |-> rsp_tdata == '0)
      else $error("zero interval with nonzero shares");

   a_busy_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pct_ff[IDLE_SLOT] <= FULL_SCALE && pct_ff[0] <= FULL_SCALE)
      else $error("share above full scale");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVWAIT)
      else $error("divider finished outside its wait state");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> total_ff != '0)
      else $error("division started with zero total");

endmodule

`default_nettype wire
